### src/pattern_occurrence_counter_macros.svh
// Assertion helpers used by the pattern counter top level.
`ifndef PATTERN_OCCURRENCE_COUNTER_MACROS_SVH
`define PATTERN_OCCURRENCE_COUNTER_MACROS_SVH

// cond true in a cycle implies prop in the same cycle
`define POC_ASSERT_IMPLIES(label, clk, rst, cond, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (prop)) \
      else $error(msg);

// cond true in a cycle implies prop in the next cycle
`define POC_ASSERT_NEXT(label, clk, rst, cond, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) \
      else $error(msg);

// cond never holds
`define POC_ASSERT_NEVER(label, clk, rst, cond, msg) \
   label: assert property (@(posedge clk) disable iff (rst) !(cond)) \
      else $error(msg);

`endif

### src/pocnt_pkg.sv
`default_nettype none
package pocnt_pkg;

   localparam int MAX_PATTERN_DEF = 16;
   localparam int COUNT_BITS_DEF  = 16;

   // bytes the two pattern registers can hold
   localparam int PATTERN_BYTES   = 16;
   localparam int LENGTH_BITS     = 5;
   localparam int CSR_INDEX_BITS  = 2;
   localparam int CSR_DATA_BITS   = 64;
   localparam int OUT_COUNT_BITS  = 16;

   // front-to-back queue, power of two
   localparam int QUEUE_DEPTH     = 2;
   localparam int QUEUE_PTR_BITS  = $clog2(QUEUE_DEPTH);
   localparam int QUEUE_LVL_BITS  = $clog2(QUEUE_DEPTH + 1);

   localparam logic [CSR_INDEX_BITS-1:0] REG_PATTERN_LENGTH = 2'd0;
   localparam logic [CSR_INDEX_BITS-1:0] REG_PATTERN_LOW    = 2'd1;
   localparam logic [CSR_INDEX_BITS-1:0] REG_PATTERN_HIGH   = 2'd2;

   typedef struct packed {
      logic [LENGTH_BITS-1:0]                pattern_length;
      logic [PATTERN_BYTES-1:0][7:0]         pattern_bytes;
   } pocnt_cfg_type;

   typedef struct packed {
      logic hit;
      logic last;
   } pocnt_item_type;

   typedef struct packed {
      logic                      full;
      logic [QUEUE_LVL_BITS-1:0] level;
   } pocnt_queue_status_type;

endpackage
`default_nettype wire

### src/pocnt_front.sv
`default_nettype none
module pocnt_front
   import pocnt_pkg::*;
#(
   parameter int MAX_PATTERN = MAX_PATTERN_DEF
) (
   input  wire logic           clock,
   input  wire logic           reset,
   input  wire pocnt_cfg_type  cfg,
   input  wire logic           in_valid,
   output logic                in_ready,
   input  wire logic [7:0]     in_byte,
   input  wire logic           in_last,
   output logic                push_valid,
   output pocnt_item_type      push_item,
   input  wire logic           push_ready
);

   localparam int USE_LIMIT = (MAX_PATTERN < PATTERN_BYTES) ? MAX_PATTERN : PATTERN_BYTES;
   localparam int SEEN_BITS = $clog2(MAX_PATTERN + 1);
   localparam int CMP_BITS  = (SEEN_BITS > LENGTH_BITS) ? SEEN_BITS : LENGTH_BITS;
   localparam logic [SEEN_BITS-1:0] SEEN_MAX = SEEN_BITS'(MAX_PATTERN);

   logic [MAX_PATTERN-1:0][7:0] window_ff, window_in;
   logic [SEEN_BITS-1:0]        seen_ff, seen_in, seen_next;
   logic [LENGTH_BITS-1:0]      len_eff;
   logic [USE_LIMIT-1:0]        byte_ok;
   logic                        accept;
   logic                        enough;
   logic                        hit;

   assign in_ready = push_ready;
   assign accept   = in_valid && push_ready;

   always_comb begin
      window_in[0] = in_byte;
      for (int i = 1; i < MAX_PATTERN; i++) begin
         window_in[i] = window_ff[i-1];
      end
   end

   assign seen_next = (seen_ff == SEEN_MAX) ? seen_ff : seen_ff + 1'b1;
   assign seen_in   = in_last ? '0 : seen_next;

   assign len_eff = (cfg.pattern_length > LENGTH_BITS'(USE_LIMIT)) ?
                    LENGTH_BITS'(USE_LIMIT) : cfg.pattern_length;

   // window position i holds the byte that pairs with pattern byte len-1-i
   always_comb begin
      logic [LENGTH_BITS-1:0] pidx;
      for (int i = 0; i < USE_LIMIT; i++) begin
         pidx = len_eff - LENGTH_BITS'(i) - 1'b1;
         if (LENGTH_BITS'(i) < len_eff) begin
            byte_ok[i] = (window_in[i] == cfg.pattern_bytes[pidx[3:0]]);
         end else begin
            byte_ok[i] = 1'b1;
         end
      end
   end

   assign enough = CMP_BITS'(seen_next) >= CMP_BITS'(len_eff);
   assign hit    = (len_eff != '0) && enough && (&byte_ok);

   assign push_valid     = in_valid;
   assign push_item.hit  = hit;
   assign push_item.last = in_last;

   always_ff @(posedge clock) begin
      if (reset) begin
         seen_ff <= '0;
      end else if (accept) begin
         seen_ff <= seen_in;
      end
      if (accept) begin
         window_ff <= window_in;
      end
   end

endmodule
`default_nettype wire

### src/pocnt_queue.sv
`default_nettype none
module pocnt_queue
   import pocnt_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              push_valid,
   input  wire pocnt_item_type    push_item,
   output logic                   push_ready,
   output logic                   pop_valid,
   output pocnt_item_type         pop_item,
   input  wire logic              pop_ready,
   output pocnt_queue_status_type status
);

   pocnt_item_type              entry_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_BITS-1:0]   wr_ptr_ff, rd_ptr_ff;
   logic [QUEUE_LVL_BITS-1:0]   level_ff, level_in;
   logic                        push, pop;

   assign push_ready = (level_ff != QUEUE_LVL_BITS'(QUEUE_DEPTH));
   assign pop_valid  = (level_ff != '0);
   assign push       = push_valid && push_ready;
   assign pop        = pop_valid && pop_ready;
   assign pop_item   = entry_ff[rd_ptr_ff];

   assign status.full  = !push_ready;
   assign status.level = level_ff;

   always_comb begin
      level_in = level_ff;
      if (push && !pop) begin
         level_in = level_ff + 1'b1;
      end else if (pop && !push) begin
         level_in = level_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         level_ff  <= '0;
      end else begin
         level_ff <= level_in;
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + 1'b1;
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + 1'b1;
         end
      end
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule
`default_nettype wire

### src/pocnt_back.sv
`default_nettype none
module pocnt_back
   import pocnt_pkg::*;
#(
   parameter int COUNT_BITS = COUNT_BITS_DEF
) (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     item_valid,
   input  wire pocnt_item_type           item,
   output logic                          item_ready,
   output logic                          out_valid,
   input  wire logic                     out_ready,
   output logic [OUT_COUNT_BITS-1:0]     out_count,
   output logic                          out_found
);

   localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

   logic [COUNT_BITS-1:0] count_ff, count_in, count_sum;
   logic [COUNT_BITS-1:0] result_ff, result_in;
   logic                  valid_ff, valid_in;
   logic                  pop;

   // words without last never touch the output slot
   assign item_ready = !item.last || !valid_ff || out_ready;
   assign pop        = item_valid && item_ready;

   assign count_sum = (item.hit && count_ff != COUNT_MAX) ? count_ff + 1'b1 : count_ff;

   always_comb begin
      count_in  = count_ff;
      result_in = result_ff;
      valid_in  = valid_ff && !out_ready;
      if (pop) begin
         count_in = count_sum;
         if (item.last) begin
            count_in  = '0;
            result_in = count_sum;
            valid_in  = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         valid_ff <= 1'b0;
      end else begin
         count_ff <= count_in;
         valid_ff <= valid_in;
      end
      result_ff <= result_in;
   end

   assign out_valid = valid_ff;
   assign out_count = OUT_COUNT_BITS'(result_ff);
   assign out_found = (result_ff != '0);

endmodule
`default_nettype wire

### src/pattern_occurrence_counter.sv
// A word with tlast set has its result registered in the queue, then in the counter's output slot, before rsp.
// Throughput: one text byte per cycle while the queue has room; the window compare is fully parallel.
// A two-word queue separates the compare stage from the counter, which owns the output.
// Reset (synchronous): pattern length 1, pattern bytes zero, byte and match counts cleared,
// queue and output emptied.
`default_nettype none
`include "pattern_occurrence_counter_macros.svh"
module pattern_occurrence_counter
   import pocnt_pkg::*;
#(
   parameter int MAX_PATTERN = MAX_PATTERN_DEF,
   parameter int COUNT_BITS  = COUNT_BITS_DEF
) (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      req_tvalid,
   output logic                           req_tready,
   input  wire logic [7:0]                req_tdata,   // text_byte
   input  wire logic                      req_tlast,
   output logic                           rsp_tvalid,
   input  wire logic                      rsp_tready,
   output logic [OUT_COUNT_BITS-1:0]      rsp_tdata,   // match_count
   output logic                           rsp_tuser,   // found
   input  wire logic                      csr_valid,
   output logic                           csr_ready,
   input  wire logic [CSR_INDEX_BITS-1:0] csr_index,
   input  wire logic [CSR_DATA_BITS-1:0]  csr_data
);

   logic [LENGTH_BITS-1:0]   length_ff;
   logic [CSR_DATA_BITS-1:0] low_ff, high_ff;
   pocnt_cfg_type            cfg;

   logic                     push_valid, push_ready;
   pocnt_item_type           push_item;
   logic                     pop_valid, pop_ready;
   pocnt_item_type           pop_item;
   pocnt_queue_status_type   q_status;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         length_ff <= LENGTH_BITS'(1);
         low_ff    <= '0;
         high_ff   <= '0;
      end else if (csr_valid) begin
         case (csr_index)
            REG_PATTERN_LENGTH: length_ff <= csr_data[LENGTH_BITS-1:0];
            REG_PATTERN_LOW:    low_ff    <= csr_data;
            REG_PATTERN_HIGH:   high_ff   <= csr_data;
            default: ;
         endcase
      end
   end

   assign cfg.pattern_length = length_ff;
   assign cfg.pattern_bytes  = {high_ff, low_ff};

   pocnt_front #(
      .MAX_PATTERN(MAX_PATTERN)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg),
      .in_valid   (req_tvalid),
      .in_ready   (req_tready),
      .in_byte    (req_tdata),
      .in_last    (req_tlast),
      .push_valid (push_valid),
      .push_item  (push_item),
      .push_ready (push_ready)
   );

   pocnt_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_item  (push_item),
      .push_ready (push_ready),
      .pop_valid  (pop_valid),
      .pop_item   (pop_item),
      .pop_ready  (pop_ready),
      .status     (q_status)
   );

   pocnt_back #(
      .COUNT_BITS(COUNT_BITS)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .item_valid (pop_valid),
      .item       (pop_item),
      .item_ready (pop_ready),
      .out_valid  (rsp_tvalid),
      .out_ready  (rsp_tready),
      .out_count  (rsp_tdata),
      .out_found  (rsp_tuser)
   );

   `POC_ASSERT_NEVER(a_queue_level, clock, reset, q_status.level > QUEUE_LVL_BITS'(QUEUE_DEPTH), "queue level beyond depth")
   `POC_ASSERT_NEXT(a_word_queued, clock, reset, req_tvalid && req_tready, pop_valid, "accepted word missing from queue")
   `POC_ASSERT_NEVER(a_result_overrun, clock, reset, pop_valid && pop_ready && pop_item.last && rsp_tvalid && !rsp_tready, "result overwritten while stalled")
   `POC_ASSERT_IMPLIES(a_full_stall, clock, reset, q_status.full, !req_tready, "word taken while queue full")

endmodule
`default_nettype wire

### tb/sv/pattern_occurrence_counter_checker.sv
`timescale 1ns / 1ps
module pattern_occurrence_counter_checker
   import pocnt_pkg::*;
(
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      req_tvalid,
   input  wire logic                      req_tready,
   input  wire logic [7:0]                req_tdata,   // text_byte
   input  wire logic                      req_tlast,
   input  wire logic                      rsp_tvalid,
   input  wire logic                      rsp_tready,
   input  wire logic [OUT_COUNT_BITS-1:0] rsp_tdata,   // match_count
   input  wire logic                      rsp_tuser,   // found
   input  wire logic                      csr_valid,
   input  wire logic                      csr_ready,
   input  wire logic [CSR_INDEX_BITS-1:0] csr_index,
   input  wire logic [CSR_DATA_BITS-1:0]  csr_data,
   input  wire logic                      end_of_test,
   output int                             failures,
   output int                             pending,
   output int                             counts_checked
);

   typedef struct packed {
      logic [OUT_COUNT_BITS-1:0] count;
      logic                      found;
   } tally_type;

   tally_type                     tallies_due[$];
   logic [7:0]                    window [MAX_PATTERN_DEF];   // newest byte at 0
   int unsigned                   seen;
   logic [OUT_COUNT_BITS-1:0]     run_count;
   logic [LENGTH_BITS-1:0]        pat_len;
   logic [8*PATTERN_BYTES-1:0]    pat_bytes;
   bit                            closed;

   task automatic report(input string what);
      $display("checker @%0t: %s", $realtime, what);
      failures++;
   endtask

   task automatic clear_text();
      foreach (window[k]) window[k] = 8'h00;
      seen = 0;
      run_count = '0;
   endtask

   task automatic take_byte(input logic [7:0] b, input logic l);
      int        alen;
      bit        hit;
      tally_type t;
      for (int k = MAX_PATTERN_DEF - 1; k > 0; k--) window[k] = window[k-1];
      window[0] = b;
      if (seen < MAX_PATTERN_DEF) seen++;
      alen = int'(pat_len);
      if (alen > MAX_PATTERN_DEF) alen = MAX_PATTERN_DEF;
      if (alen > PATTERN_BYTES) alen = PATTERN_BYTES;
      hit = (alen > 0) && (seen >= alen);
      // the oldest of the alen compared bytes lines up with pattern byte 0
      for (int j = 0; j < alen; j++)
         if (window[alen-1-j] != pat_bytes[8*j +: 8]) hit = 1'b0;
      if (hit && run_count != '1) run_count++;
      if (l) begin
         t.count = run_count;
         t.found = (run_count != 0);
         tallies_due.push_back(t);
         clear_text();
      end
   endtask

   always @(posedge clock) begin : watch
      tally_type want;
      if (reset) begin
         tallies_due.delete();
         clear_text();
         pat_len = 5'd1;
         pat_bytes = '0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (tallies_due.size() == 0) begin
               report($sformatf("count %0d found %0b with no text ended", rsp_tdata,
                                rsp_tuser));
            end else begin
               want = tallies_due.pop_front();
               counts_checked++;
               if (rsp_tdata !== want.count)
                  report($sformatf("match_count %0d, want %0d", rsp_tdata, want.count));
               if (rsp_tuser !== want.found)
                  report($sformatf("found %0b, want %0b", rsp_tuser, want.found));
            end
         end
         if (req_tvalid && req_tready) take_byte(req_tdata, req_tlast);
         if (csr_valid && csr_ready) begin
            case (csr_index)
               REG_PATTERN_LENGTH: pat_len = csr_data[LENGTH_BITS-1:0];
               REG_PATTERN_LOW:    pat_bytes[0 +: 64] = csr_data;
               REG_PATTERN_HIGH:   pat_bytes[64 +: 64] = csr_data;
               default: ;
            endcase
         end
         if (end_of_test && !closed) begin
            closed = 1'b1;
            if (tallies_due.size() != 0)
               report($sformatf("%0d counts never arrived", tallies_due.size()));
         end
      end
      pending <= tallies_due.size();
   end

endmodule

### tb/sv/pattern_occurrence_counter_tb.sv
`timescale 1ns / 1ps
module pattern_occurrence_counter_tb;
   import pocnt_pkg::*;

   localparam int CLK_PERIOD     = 20;
   localparam int TIMEOUT_CYCLES = 1000000;
   localparam int DRAIN_CYCLES   = 4;
   localparam int RANDOM_BYTES   = 1100;
   localparam logic [CSR_INDEX_BITS-1:0] REG_UNUSED = 2'd3;

   logic                      clock = 1'b0;
   logic                      reset = 1'b1;
   logic                      req_tvalid = 1'b0;
   logic                      req_tready;
   logic [7:0]                req_tdata = 8'h00;   // text_byte
   logic                      req_tlast = 1'b0;
   logic                      rsp_tvalid;
   logic                      rsp_tready = 1'b0;
   logic [OUT_COUNT_BITS-1:0] rsp_tdata;           // match_count
   logic                      rsp_tuser;           // found
   logic                      csr_valid = 1'b0;
   logic                      csr_ready;
   logic [CSR_INDEX_BITS-1:0] csr_index = '0;
   logic [CSR_DATA_BITS-1:0]  csr_data = '0;
   logic                      end_of_test = 1'b0;

   int failures;
   int pending;
   int counts_checked;

   int gap_pct = 0;
   int stall_pct = 0;
   int bytes_sent = 0;
   int texts_sent = 0;
   int settings_used = 0;
   logic [4:0]   cur_len = 5'd1;
   logic [127:0] cur_pat = '0;
   logic [7:0]   text_q[$];

   int gap_tab[4]   = '{0, 76, 0, 9};
   int stall_tab[4] = '{0, 0, 76, 9};

   always #(CLK_PERIOD / 2) clock = ~clock;

   pattern_occurrence_counter dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   pattern_occurrence_counter_checker checker_i (
      .clock          (clock),
      .reset          (reset),
      .req_tvalid     (req_tvalid),
      .req_tready     (req_tready),
      .req_tdata      (req_tdata),
      .req_tlast      (req_tlast),
      .rsp_tvalid     (rsp_tvalid),
      .rsp_tready     (rsp_tready),
      .rsp_tdata      (rsp_tdata),
      .rsp_tuser      (rsp_tuser),
      .csr_valid      (csr_valid),
      .csr_ready      (csr_ready),
      .csr_index      (csr_index),
      .csr_data       (csr_data),
      .end_of_test    (end_of_test),
      .failures       (failures),
      .pending        (pending),
      .counts_checked (counts_checked)
   );

   always @(posedge clock) begin
      rsp_tready <= ($urandom_range(99) >= stall_pct);
   end

   // valid stays high into the next word unless a gap is rolled
   task automatic send_word(input logic [7:0] b, input logic l);
      if (gap_pct != 0 && $urandom_range(99) < gap_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
         while ($urandom_range(99) < gap_pct) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= b;
      req_tlast  <= l;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      bytes_sent++;
   endtask

   task automatic send_text();
      foreach (text_q[i]) send_word(text_q[i], i == text_q.size() - 1);
      texts_sent++;
   endtask

   // wait for all counts, then let words still in the pipe drain
   task automatic settle();
      int waited;
      req_tvalid <= 1'b0;
      @(posedge clock);
      waited = 0;
      while (pending != 0 && waited < 5000) begin
         @(posedge clock);
         waited++;
      end
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic load_pattern(input logic [4:0] len, input logic [127:0] pat,
                               input bit junk);
      logic [CSR_INDEX_BITS-1:0] idx [4];
      logic [CSR_DATA_BITS-1:0]  val [4];
      int                        n;
      idx[0] = REG_PATTERN_LENGTH;
      val[0] = {$urandom, $urandom};
      val[0][LENGTH_BITS-1:0] = len;
      idx[1] = REG_PATTERN_LOW;
      val[1] = pat[0 +: 64];
      idx[2] = REG_PATTERN_HIGH;
      val[2] = pat[64 +: 64];
      idx[3] = REG_UNUSED;
      val[3] = {$urandom, $urandom};
      n = junk ? 4 : 3;
      for (int i = 0; i < n; i++) begin
         csr_valid <= 1'b1;
         csr_index <= idx[i];
         csr_data  <= val[i];
         @(posedge clock);
         while (!csr_ready) @(posedge clock);
      end
      csr_valid <= 1'b0;
      cur_len = len;
      cur_pat = pat;
      settings_used++;
   endtask

   task automatic random_setting();
      logic [4:0]   len;
      logic [127:0] pat;
      logic [7:0]   a;
      logic [7:0]   b;
      case ($urandom_range(7))
         0:       len = 5'd0;
         1:       len = 5'd1;
         2:       len = 5'd16;
         3:       len = 5'($urandom_range(17, 31));
         default: len = 5'($urandom_range(2, 15));
      endcase
      case ($urandom_range(5))
         0:       pat = '1;
         1:       pat = {$urandom, $urandom, $urandom, $urandom};
         default: begin
            // two-symbol patterns give plenty of overlapping hits
            a = 8'($urandom);
            b = 8'($urandom);
            for (int j = 0; j < 16; j++) pat[8*j +: 8] = $urandom_range(1) ? a : b;
         end
      endcase
      load_pattern(len, pat, $urandom_range(2) == 0);
   endtask

   task automatic build_text(input int n, input bit noise);
      int alen;
      int r;
      int last_i;
      alen = (cur_len > 16) ? 16 : int'(cur_len);
      text_q.delete();
      while (text_q.size() < n) begin
         r = $urandom_range(9);
         if (!noise && alen > 0 && r < 3) begin
            for (int j = 0; j < alen; j++) text_q.push_back(cur_pat[8*j +: 8]);
            if (r == 2) begin
               // near miss: one bit off in the final pattern byte
               last_i = text_q.size() - 1;
               text_q[last_i] = text_q[last_i] ^ (8'h01 << $urandom_range(7));
            end
         end else if (!noise && alen > 0 && r < 7) begin
            text_q.push_back(cur_pat[8*$urandom_range(alen - 1) +: 8]);
         end else begin
            text_q.push_back(8'($urandom));
         end
      end
   endtask

   initial begin
      logic [127:0] alt;
      int           goal;
      int           n;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // reset pattern: one zero byte
      text_q = '{8'h00};
      send_text();
      text_q = '{8'hFF, 8'h00};
      send_text();
      settle();

      for (int j = 0; j < 16; j++) alt[8*j +: 8] = (j % 2) ? 8'h00 : 8'hFF;
      load_pattern(5'd16, alt, 1'b0);
      text_q.delete();
      for (int j = 0; j < 18; j++) text_q.push_back((j % 2) ? 8'h00 : 8'hFF);
      send_text();
      settle();

      // length beyond the register bytes clamps to 16
      load_pattern(5'd31, alt, 1'b0);
      text_q.delete();
      for (int j = 0; j < 16; j++) text_q.push_back((j % 2) ? 8'h00 : 8'hFF);
      send_text();
      settle();

      load_pattern(5'd0, alt, 1'b0);
      text_q = '{8'hFF, 8'h00};
      send_text();
      settle();

      for (int ph = 0; ph < 4; ph++) begin
         gap_pct = gap_tab[ph];
         stall_pct <= stall_tab[ph];
         for (int s = 0; s < 3; s++) begin
            random_setting();
            goal = bytes_sent + RANDOM_BYTES / 12;
            while (bytes_sent < goal) begin
               n = ($urandom_range(3) == 0) ? $urandom_range(17, 40) : $urandom_range(1, 12);
               build_text(n, $urandom_range(9) == 0);
               send_text();
            end
            settle();
         end
      end

      end_of_test <= 1'b1;
      repeat (2) @(posedge clock);
      $display("run: %0d text bytes in %0d texts over %0d pattern settings, %0d counts checked",
               bytes_sent, texts_sent, settings_used, counts_checked);
      $display("run: covered zero and clamped lengths, overlapping hits, ignored register index");
      if (failures == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

   initial begin
      #(CLK_PERIOD * TIMEOUT_CYCLES);
      $display("TB_ERROR");
      $finish;
   end

endmodule
